@@ rtl/llswt_pkg.sv @@
// Package for the segment window tracker: function codes, widths,
// default sizes and the constants of the millisecond rounding.
// No dependencies.
`default_nettype none

package llswt_pkg;

    localparam int FUNC_W = 3;
    localparam int WD_W   = 7;
    localparam int WORD_W = 32;
    localparam int PART_IDX_W = 8;
    localparam int TIME_W = 64;

    localparam int RING_DEPTH_DEF = 64;
    localparam int PART_LIMIT_DEF = 16;
    localparam logic [WD_W-1:0] WINDOW_DEPTH_RST = 7'd64;

    // (d + 500) / 1000 is taken as ((d + 500) >> 3) / 125.
    // The quotient by 125 comes from a truncated reciprocal of 2^37 / 125,
    // low by at most one, then fixed with one compare.
    localparam int MS_Y_W   = 30;
    localparam int MS_Q_W   = 24;
    localparam int MS_SHIFT = 37;
    localparam int MS_PROD_W = 61;
    localparam logic [30:0] MS_RECIP = 31'd1099511627;
    localparam logic [32:0] ROUND_US = 33'd500;
    localparam logic [MS_Y_W-1:0] MS_DIV = 30'd125;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_SEG  = 3'd0,
        FN_PUSH_PART = 3'd1,
        FN_CLOSE     = 3'd2,
        FN_QUERY     = 3'd3,
        FN_ENABLE_LL = 3'd4
    } t_func;

endpackage

`default_nettype wire

@@ rtl/ll_segment_window_tracker.sv @@
// Segment window tracker top level: four-stage pipeline with the window
// state updated in the last stage. Depends on llswt_pkg.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      func, size_bytes, duration_us,
//                                                   want_seg, want_part
// out       output     o_out_valid / i_out_ready    status .. target_duration_us
// cfg       input      i_cfg_we                     i_cfg_wdata (window_depth)
//
// One item per cycle while no result waits untaken; an item passes through stages
// 1, 2 and 3 into the result register before its output transfer.
// The millisecond rounding takes two stages (reciprocal multiply, then fix-up),
// the part-count memory read runs beside the fix-up, and the window state
// updates in the last. When a result waits and is not taken, the whole pipeline
// holds. Synchronous reset clears the pipeline and the window; the part-count
// memory needs no clearing, only entries inside the window are ever used.

module ll_segment_window_tracker
#(
    parameter int RING_DEPTH = llswt_pkg::RING_DEPTH_DEF,
    parameter int PART_LIMIT = llswt_pkg::PART_LIMIT_DEF
)
(
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    input  wire logic                                  i_cfg_we,
    input  wire logic [llswt_pkg::WD_W-1:0]            i_cfg_wdata,

    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [llswt_pkg::FUNC_W-1:0]          i_func,
    input  wire logic [llswt_pkg::WORD_W-1:0]          i_size_bytes,
    input  wire logic [llswt_pkg::WORD_W-1:0]          i_duration_us,
    input  wire logic [llswt_pkg::WORD_W-1:0]          i_want_seg,
    input  wire logic [llswt_pkg::PART_IDX_W-1:0]      i_want_part,

    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_status,
    output logic [llswt_pkg::WORD_W-1:0]               o_seq,
    output logic [llswt_pkg::WORD_W-1:0]               o_part_offset,
    output logic [llswt_pkg::TIME_W-1:0]               o_start_ms,
    output logic                                       o_available,
    output logic                                       o_store_ready,
    output logic                                       o_ll_ready,
    output logic [llswt_pkg::WORD_W-1:0]               o_oldest_seq,
    output logic [$clog2(RING_DEPTH+1)-1:0]            o_entry_count,
    output logic [llswt_pkg::WORD_W-1:0]               o_target_duration_us
);

    import llswt_pkg::*;

    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > WD_W) ? CNT_W : WD_W;
    localparam int PART_W    = $clog2(PART_LIMIT + 1);
    localparam int MEM_AW    = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = 1 << MEM_AW;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [WORD_W-1:0]     size;
        logic [WORD_W-1:0]     dur;
        logic [WORD_W-1:0]     ask_seg;
        logic [PART_IDX_W-1:0] ask_part;
    } t_item;

    typedef struct packed {
        t_item             item;
        logic [MS_Y_W-1:0] y;
        logic [MS_Q_W-1:0] q0;
    } t_s2;

    typedef struct packed {
        t_item             item;
        logic [MS_Q_W-1:0] ms_add;
        logic [PART_W-1:0] parts;
    } t_s3;

    function automatic logic [CNT_W-1:0] clamp_depth(input logic [WD_W-1:0] d);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(d);
        if (ext == '0) begin
            return CNT_W'(1);
        end else if (ext > CMP_W'(RING_DEPTH)) begin
            return CNT_W'(RING_DEPTH);
        end
        return CNT_W'(ext);
    endfunction

    logic en;

    // pipeline
    logic         r_s1_valid, r_s2_valid, r_s3_valid;
    t_item        r_s1;
    t_s2          r_s2;
    t_s3          r_s3;
    logic [32:0]  s1_rounded;
    logic [MS_PROD_W-1:0] s1_prod;
    logic [MS_Y_W-1:0]    s2_q125;
    logic [MS_Y_W-1:0]    s2_rem;
    logic [MS_Q_W-1:0]    s2_ms_add;

    // part-count store, indexed by sequence number
    logic [PART_W-1:0] r_seg_parts [MEM_DEPTH];
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [PART_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] mem_raddr;

    // window state
    logic [CNT_W-1:0]  r_eff_depth;
    logic [CNT_W-1:0]  r_ring_count, n_ring_count;
    logic [WORD_W-1:0] r_oldest, n_oldest;
    logic [WORD_W-1:0] r_next, n_next;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [WORD_W-1:0] r_max_dur, n_max_dur;
    logic [WORD_W-1:0] r_live_num, n_live_num;
    logic [WORD_W-1:0] r_live_len, n_live_len;
    logic [PART_W-1:0] r_live_parts, n_live_parts;
    logic              r_ll_on, n_ll_on;

    // result register
    logic              r_out_valid;
    logic              r_status, n_status;
    logic [WORD_W-1:0] r_seq, n_seq;
    logic [WORD_W-1:0] r_poff, n_poff;
    logic [TIME_W-1:0] r_start, n_start;
    logic              r_avail, n_avail;

    logic              full;
    logic [TIME_W:0]   elapsed_sum;
    logic [WORD_W:0]   len_sum;
    logic [WORD_W-1:0] q_off;
    logic              q_in_window;
    logic [PART_IDX_W-1:0] q_stored;
    logic [PART_IDX_W-1:0] q_live;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en && i_rst_n;

    // stage 1 -> 2: reciprocal multiply
    assign s1_rounded = {1'b0, r_s1.dur} + ROUND_US;
    assign s1_prod    = MS_PROD_W'(s1_rounded[32:3]) * MS_PROD_W'(MS_RECIP);

    // stage 2 -> 3: fix the quotient up by one where the remainder overflows
    assign s2_q125   = (MS_Y_W'(r_s2.q0) << 7) - (MS_Y_W'(r_s2.q0) << 1) - MS_Y_W'(r_s2.q0);
    assign s2_rem    = r_s2.y - s2_q125;
    assign s2_ms_add = (s2_rem >= MS_DIV) ? r_s2.q0 + MS_Q_W'(1) : r_s2.q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.func      <= i_func;
            r_s1.size      <= i_size_bytes;
            r_s1.dur       <= i_duration_us;
            r_s1.ask_seg   <= i_want_seg;
            r_s1.ask_part  <= i_want_part;
            r_s2.item      <= r_s1;
            r_s2.y         <= s1_rounded[32:3];
            r_s2.q0        <= s1_prod[MS_PROD_W-1:MS_SHIFT];
            r_s3.item      <= r_s2.item;
            r_s3.ms_add    <= s2_ms_add;
            // forward the entry written at the same edge
            if (mem_we && mem_waddr == mem_raddr) begin
                r_s3.parts <= mem_wdata;
            end else begin
                r_s3.parts <= r_seg_parts[mem_raddr];
            end
        end
    end

    // part-count memory: write from the update stage, read for the next query
    assign mem_we    = en && r_s3_valid &&
                       (r_s3.item.func == FN_PUSH_SEG || r_s3.item.func == FN_CLOSE);
    assign mem_waddr = r_next[MEM_AW-1:0];
    assign mem_wdata = (r_s3.item.func == FN_CLOSE) ? r_live_parts : '0;
    assign mem_raddr = r_s2.item.ask_seg[MEM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_seg_parts[mem_waddr] <= mem_wdata;
        end
    end

    // update stage
    assign full        = r_ring_count >= r_eff_depth;
    assign elapsed_sum = {1'b0, r_elapsed} + (TIME_W + 1)'(r_s3.ms_add);
    assign len_sum     = {1'b0, r_live_len} + {1'b0, r_s3.item.size};
    assign q_off       = r_s3.item.ask_seg - r_oldest;
    assign q_in_window = (r_ring_count != '0) && (q_off < WORD_W'(r_ring_count));
    assign q_stored    = PART_IDX_W'(r_s3.parts);
    assign q_live      = PART_IDX_W'(r_live_parts);

    always_comb begin
        n_ring_count = r_ring_count;
        n_oldest     = r_oldest;
        n_next       = r_next;
        n_elapsed    = r_elapsed;
        n_max_dur    = r_max_dur;
        n_live_num   = r_live_num;
        n_live_len   = r_live_len;
        n_live_parts = r_live_parts;
        n_ll_on      = r_ll_on;
        n_status     = 1'b0;
        n_seq        = '0;
        n_poff       = '0;
        n_start      = '0;
        n_avail      = 1'b0;

        unique case (r_s3.item.func)
            FN_PUSH_SEG, FN_CLOSE: begin
                // evict the oldest when full, then append at the next number
                if (full) begin
                    n_oldest = r_oldest + 1'b1;
                end else begin
                    n_ring_count = r_ring_count + 1'b1;
                end
                n_seq     = r_next;
                n_start   = r_elapsed;
                n_elapsed = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
                n_next    = r_next + 1'b1;
                if (r_s3.item.dur > r_max_dur) begin
                    n_max_dur = r_s3.item.dur;
                end
                if (r_s3.item.func == FN_CLOSE) begin
                    n_live_len   = '0;
                    n_live_parts = '0;
                    n_live_num   = r_next + 1'b1;
                end
            end
            FN_PUSH_PART: begin
                n_seq = r_live_num;
                if (r_live_parts >= PART_W'(PART_LIMIT)) begin
                    n_status = 1'b1;
                end else begin
                    n_poff       = r_live_len;
                    n_live_parts = r_live_parts + 1'b1;
                    n_live_len   = len_sum[WORD_W] ? '1 : len_sum[WORD_W-1:0];
                end
            end
            FN_QUERY: begin
                // a closed segment with no parts still answers for part zero
                n_avail = ((r_live_num == r_s3.item.ask_seg) &&
                           (q_live > r_s3.item.ask_part)) ||
                          (q_in_window &&
                           ((q_stored > r_s3.item.ask_part) ||
                            (r_s3.item.ask_part == '0 && q_stored == '0)));
            end
            FN_ENABLE_LL: begin
                n_ll_on    = r_s3.item.dur != '0;
                n_live_num = r_next;
            end
            default: begin
                // unknown function: no state change
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_depth  <= clamp_depth(WINDOW_DEPTH_RST);
            r_ring_count <= '0;
            r_oldest     <= '0;
            r_next       <= '0;
            r_elapsed    <= '0;
            r_max_dur    <= '0;
            r_live_num   <= '0;
            r_live_len   <= '0;
            r_live_parts <= '0;
            r_ll_on      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eff_depth <= clamp_depth(i_cfg_wdata);
            end
            if (en && r_s3_valid) begin
                r_ring_count <= n_ring_count;
                r_oldest     <= n_oldest;
                r_next       <= n_next;
                r_elapsed    <= n_elapsed;
                r_max_dur    <= n_max_dur;
                r_live_num   <= n_live_num;
                r_live_len   <= n_live_len;
                r_live_parts <= n_live_parts;
                r_ll_on      <= n_ll_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= n_status;
            r_seq    <= n_seq;
            r_poff   <= n_poff;
            r_start  <= n_start;
            r_avail  <= n_avail;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_seq                = r_seq;
    assign o_part_offset        = r_poff;
    assign o_start_ms           = r_start;
    assign o_available          = r_avail;
    // window status follows the state left by the last committed item
    assign o_store_ready        = r_ring_count != '0;
    assign o_ll_ready           = r_ll_on && (r_ring_count != '0 || r_live_parts != '0);
    assign o_oldest_seq         = r_oldest;
    assign o_entry_count        = r_ring_count;
    assign o_target_duration_us = r_max_dur;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for ll_segment_window_tracker: a directed table, then random
// event streams under several window depths, with bursty input and a stalling output.
// Depends on llswt_pkg and the tracker RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import llswt_pkg::*;

    localparam int RING = RING_DEPTH_DEF;
    localparam int SLOT_W = $clog2(RING);
    localparam int CNT_W = $clog2(RING + 1);
    localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [WORD_W-1:0]     size;
        logic [WORD_W-1:0]     dur;
        logic [WORD_W-1:0]     seg;
        logic [PART_IDX_W-1:0] part;
    } t_ev_item;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] part_off;
        logic [TIME_W-1:0] seg_start;
        logic              avail;
        logic              store_rdy;
        logic              ll_rdy;
        logic [WORD_W-1:0] oldest;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] target;
    } t_win_report;

    typedef struct packed {
        t_ev_item    ev;
        logic        typed;
        t_win_report exp;
    } t_dir_row;

    localparam int N_DIR = 19;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd0, 8'd0}, 1'b1, '0},
        '{'{FN_PUSH_PART, ALL_ONES, 32'd0, 32'd0, 8'd0}, 1'b1, '0},
        '{'{FN_PUSH_PART, 32'd5, 32'd0, 32'd0, 8'd0}, 1'b1,
          '{1'b0, 32'd0, ALL_ONES, 64'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd0, 8'd1}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 64'd0, 1'b1, 1'b0, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{'{FN_RSVD_7, ALL_ONES, ALL_ONES, ALL_ONES, 8'hFF}, 1'b1, '0},
        '{'{FN_PUSH_SEG, 32'd0, ALL_ONES, 32'd0, 8'd0}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 64'd0, 1'b0, 1'b1, 1'b0, 32'd0, 7'd1, ALL_ONES}},
        '{'{FN_ENABLE_LL, 32'd0, 32'd1, 32'd0, 8'd0}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 64'd0, 1'b0, 1'b1, 1'b1, 32'd0, 7'd1, ALL_ONES}},
        // closed segment with no parts answers for part 0
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd0, 8'd0}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 64'd0, 1'b1, 1'b1, 1'b1, 32'd0, 7'd1, ALL_ONES}},
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd0, 8'd1}, 1'b0, '0},
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd1, 8'd1}, 1'b0, '0},
        '{'{FN_CLOSE, 32'd0, 32'd499, 32'd0, 8'd0}, 1'b0, '0},
        '{'{FN_CLOSE, 32'd0, 32'd500, 32'd0, 8'd0}, 1'b0, '0},
        '{'{FN_PUSH_PART, 32'd100, 32'd0, 32'd0, 8'd0}, 1'b0, '0},
        '{'{FN_QUERY, 32'd0, 32'd0, ALL_ONES, 8'hFF}, 1'b0, '0},
        '{'{FN_QUERY, 32'd0, 32'd0, 32'd1, 8'd2}, 1'b0, '0},
        '{'{FN_ENABLE_LL, 32'd0, 32'd0, 32'd0, 8'd0}, 1'b0, '0},
        '{'{FN_PUSH_SEG, ALL_ONES, 32'd0, 32'd0, 8'd0}, 1'b0, '0},
        '{'{FN_RSVD_5, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 8'hAA}, 1'b0, '0},
        '{'{FN_RSVD_6, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55}, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [WD_W-1:0]       i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [FUNC_W-1:0]     i_func;
    logic [WORD_W-1:0]     i_size_bytes;
    logic [WORD_W-1:0]     i_duration_us;
    logic [WORD_W-1:0]     i_want_seg;
    logic [PART_IDX_W-1:0] i_want_part;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_status;
    logic [WORD_W-1:0]     o_seq;
    logic [WORD_W-1:0]     o_part_offset;
    logic [TIME_W-1:0]     o_start_ms;
    logic                  o_available;
    logic                  o_store_ready;
    logic                  o_ll_ready;
    logic [WORD_W-1:0]     o_oldest_seq;
    logic [CNT_W-1:0]      o_entry_count;
    logic [WORD_W-1:0]     o_target_duration_us;

    // window state as the tracker should hold it
    logic [WD_W-1:0]   depth_reg = WINDOW_DEPTH_RST;
    logic [SLOT_W-1:0] wnd_head = '0;
    logic [CNT_W-1:0]  wnd_count = '0;
    logic [WORD_W-1:0] wnd_oldest = '0;
    logic [WORD_W-1:0] wnd_next = '0;
    logic [TIME_W-1:0] wnd_elapsed_ms = '0;
    logic [WORD_W-1:0] wnd_max_dur = '0;
    logic [WORD_W-1:0] live_num = '0;
    logic [WORD_W-1:0] cur_len = '0;
    logic [4:0]        cur_parts = '0;
    logic [WORD_W-1:0] part_goal = '0;
    logic [4:0]        seg_part_cnt [RING];

    t_win_report pending_reports [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          rx_left = 0;
    int          rx_mode = 0;
    int unsigned rx_tick = 0;

    ll_segment_window_tracker DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_func               (i_func),
        .i_size_bytes         (i_size_bytes),
        .i_duration_us        (i_duration_us),
        .i_want_seg           (i_want_seg),
        .i_want_part          (i_want_part),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_seq                (o_seq),
        .o_part_offset        (o_part_offset),
        .o_start_ms           (o_start_ms),
        .o_available          (o_available),
        .o_store_ready        (o_store_ready),
        .o_ll_ready           (o_ll_ready),
        .o_oldest_seq         (o_oldest_seq),
        .o_entry_count        (o_entry_count),
        .o_target_duration_us (o_target_duration_us)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one event to the window state and return the report it must produce.
    function automatic t_win_report track_window(t_ev_item ev);
        t_win_report       r;
        logic [WD_W-1:0]   depth;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] off;
        logic [4:0]        p;
        logic [4:0]        parts_in;
        logic [TIME_W-1:0] add;
        logic [TIME_W-1:0] sum;
        logic [WORD_W:0]   len_sum;
        r = '0;
        case (ev.func)
            FN_PUSH_SEG, FN_CLOSE: begin
                parts_in = (ev.func == FN_CLOSE) ? cur_parts : 5'd0;
                depth = depth_reg;
                if (depth == 0) depth = WD_W'(1);
                if (depth > RING) depth = WD_W'(RING);
                // evict the oldest when the window is already full
                if (wnd_count >= depth) begin
                    wnd_head = wnd_head + 1'b1;
                    wnd_count = wnd_count - 1'b1;
                    wnd_oldest = wnd_oldest + 1'b1;
                end
                slot = wnd_head + wnd_count[SLOT_W-1:0];
                seg_part_cnt[slot] = parts_in;
                r.seq = wnd_next;
                r.seg_start = wnd_elapsed_ms;
                add = ({32'd0, ev.dur} + 64'd500) / 64'd1000;
                sum = wnd_elapsed_ms + add;
                wnd_elapsed_ms = (sum < wnd_elapsed_ms) ? '1 : sum;
                wnd_next = wnd_next + 1'b1;
                wnd_count = wnd_count + 1'b1;
                if (ev.dur > wnd_max_dur) wnd_max_dur = ev.dur;
                if (ev.func == FN_CLOSE) begin
                    cur_len = '0;
                    cur_parts = '0;
                    live_num = wnd_next;
                end
            end
            FN_PUSH_PART: begin
                r.seq = live_num;
                if (cur_parts >= PART_LIMIT_DEF) begin
                    r.status = 1'b1;
                end else begin
                    r.part_off = cur_len;
                    cur_parts = cur_parts + 1'b1;
                    len_sum = {1'b0, cur_len} + {1'b0, ev.size};
                    cur_len = len_sum[WORD_W] ? '1 : len_sum[WORD_W-1:0];
                end
            end
            FN_QUERY: begin
                if (live_num == ev.seg && {3'b0, cur_parts} > ev.part) begin
                    r.avail = 1'b1;
                end else if (wnd_count != 0) begin
                    off = ev.seg - wnd_oldest;
                    if (off < wnd_count) begin
                        slot = wnd_head + off[SLOT_W-1:0];
                        p = seg_part_cnt[slot];
                        r.avail = ({3'b0, p} > ev.part) || (ev.part == 0 && p == 0);
                    end
                end
            end
            FN_ENABLE_LL: begin
                part_goal = ev.dur;
                live_num = wnd_next;
            end
            default: begin
            end
        endcase
        r.store_rdy = (wnd_count != 0);
        r.ll_rdy = (part_goal != 0) && (wnd_count != 0 || cur_parts != 0);
        r.oldest = wnd_oldest;
        r.count = wnd_count;
        r.target = wnd_max_dur;
        return r;
    endfunction

    // Build an event of the given function with values aimed at the interesting corners;
    // raw gives a fully random event of any code.
    function automatic t_ev_item shape_item(logic [FUNC_W-1:0] f, bit raw);
        t_ev_item ev;
        ev.size = $urandom;
        ev.dur = $urandom;
        ev.seg = $urandom;
        ev.part = PART_IDX_W'($urandom);
        if (raw) begin
            ev.func = FUNC_W'($urandom_range(0, 7));
            return ev;
        end
        ev.func = f;
        case (f)
            FN_PUSH_PART: begin
                case ($urandom_range(0, 5))
                    0: ev.size = '0;
                    1: ev.size = ALL_ONES;
                    2: ev.size = $urandom;
                    default: ev.size = $urandom_range(100, 2_000_000);
                endcase
            end
            FN_PUSH_SEG, FN_CLOSE, FN_ENABLE_LL: begin
                case ($urandom_range(0, 7))
                    0: ev.dur = '0;
                    1: ev.dur = ALL_ONES;
                    2: ev.dur = $urandom_range(0, 10_000) * 1000 + 499;
                    3: ev.dur = $urandom_range(0, 10_000) * 1000 + 500;
                    4: ev.dur = $urandom;
                    default: ev.dur = $urandom_range(500_000, 12_000_000);
                endcase
                if (f == FN_ENABLE_LL && $urandom_range(0, 3) == 0) ev.dur = '0;
            end
            FN_QUERY: begin
                case ($urandom_range(0, 5))
                    0: ev.seg = $urandom;
                    1: ev.seg = live_num;
                    2: ev.seg = wnd_next;
                    default: ev.seg = wnd_oldest - 1 + $urandom_range(0, wnd_count + 1);
                endcase
                if ($urandom_range(0, 9) < 7) ev.part = PART_IDX_W'($urandom_range(0, 17));
            end
            default: begin
            end
        endcase
        return ev;
    endfunction

    // Present one event, hold it until the transfer, then record what must come back.
    task automatic offer(input t_ev_item ev, input bit typed, input t_win_report typed_exp);
        int          gap;
        t_win_report pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_func <= ev.func;
        i_size_bytes <= ev.size;
        i_duration_us <= ev.dur;
        i_want_seg <= ev.seg;
        i_want_part <= ev.part;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        pred = track_window(ev);
        pending_reports.push_back(typed ? typed_exp : pred);
    endtask

    // Drop valid and hold until every pending report has come out.
    task automatic drain_reports;
        i_in_valid <= 1'b0;
        for (int k = 0; k < 20000 && pending_reports.size() != 0; k++) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [WD_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        depth_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed live segments (parts, queries, close), some full pushes,
    // and a share of raw events. Ignored codes do not count toward the quota.
    task automatic run_phase(input int quota, input bit hold_mid);
        int       sent;
        int       r;
        bit       held;
        t_ev_item ev;
        sent = 0;
        held = 1'b0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer(shape_item(FN_ENABLE_LL, 1'b0), 1'b0, '0);
                    sent++;
                end
                repeat ($urandom_range(0, 20)) begin
                    offer(shape_item(FN_PUSH_PART, 1'b0), 1'b0, '0);
                    sent++;
                    if ($urandom_range(0, 1) == 1) begin
                        offer(shape_item(FN_QUERY, 1'b0), 1'b0, '0);
                        sent++;
                    end
                end
                offer(shape_item(FN_CLOSE, 1'b0), 1'b0, '0);
                sent++;
            end else if (r < 80) begin
                offer(shape_item(FN_PUSH_SEG, 1'b0), 1'b0, '0);
                offer(shape_item(FN_QUERY, 1'b0), 1'b0, '0);
                sent += 2;
            end else if (r < 88) begin
                offer(shape_item(FN_ENABLE_LL, 1'b0), 1'b0, '0);
                sent++;
            end else begin
                ev = shape_item(FN_PUSH_SEG, 1'b1);
                offer(ev, 1'b0, '0);
                if (ev.func <= FN_ENABLE_LL) sent++;
            end
            if (hold_mid && !held && sent >= quota / 2) begin
                held = 1'b1;
                drain_reports();
            end
        end
    endtask

    // Output side: switch between always ready, random, periodic and heavy stalls.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 9) < 7);
            2: i_out_ready <= (rx_tick % 3 != 0);
            default: i_out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_win_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report transfer with nothing pending");
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("o_status", want.status, o_status);
                check_field("o_seq", want.seq, o_seq);
                check_field("o_part_offset", want.part_off, o_part_offset);
                check_field("o_start_ms", want.seg_start, o_start_ms);
                check_field("o_available", want.avail, o_available);
                check_field("o_store_ready", want.store_rdy, o_store_ready);
                check_field("o_ll_ready", want.ll_rdy, o_ll_ready);
                check_field("o_oldest_seq", want.oldest, o_oldest_seq);
                check_field("o_entry_count", want.count, o_entry_count);
                check_field("o_target_duration_us", want.target, o_target_duration_us);
            end
        end
    end

    initial begin
        logic [WD_W-1:0] depths [6];
        depths = '{7'd127, 7'd3, 7'd0, 7'd1, WD_W'($urandom_range(2, 63)), 7'd64};
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid <= 1'b0;
        i_func <= '0;
        i_size_bytes <= '0;
        i_duration_us <= '0;
        i_want_seg <= '0;
        i_want_part <= '0;
        i_out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            offer(DIR_ROWS[i].ev, DIR_ROWS[i].typed, DIR_ROWS[i].exp);
        end

        // deep depth first to fill the window, then lower it below the count
        for (int ph = 0; ph < 6; ph++) begin
            drain_reports();
            write_depth(depths[ph]);
            run_phase(100, ph == 1);
        end

        drain_reports();
        repeat (8) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/llswt_pkg.sv
rtl/ll_segment_window_tracker.sv
tb/tb.sv
